[rtl/tccw_pkg.sv]
`timescale 1ns / 1ps

package tccw_pkg;

    localparam int POS_W = 11;

    localparam logic [1:0] CMD_WRITE    = 2'd0;
    localparam logic [1:0] CMD_PROT_ON  = 2'd1;
    localparam logic [1:0] CMD_PROT_OFF = 2'd2;
    localparam logic [1:0] CMD_CLEAR    = 2'd3;

    localparam logic [7:0] CH_NEWLINE   = 8'd10;
    localparam logic [7:0] CH_BACKSPACE = 8'd8;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] ATTR_BLANK   = 8'h07;

    typedef enum logic {
        ST_SWEEP,
        ST_RUN
    } t_state;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] char_code;
        logic [7:0] attribute;
    } t_req;

    typedef struct packed {
        logic             cell_written;
        logic [POS_W-1:0] cell_index;
        logic [7:0]       cell_char;
        logic [7:0]       cell_attr;
        logic [POS_W-1:0] cursor_position;
        logic             screen_cleared;
    } t_res;

endpackage

[rtl/text_console_char_writer_unit.sv]
// a request is captured in the input register, then written to the output register when it is processed
// a new request is accepted only once the held request has been processed
// CMD_CLEAR or a full-screen wrap with clear_on_full set starts a sweep of COLUMNS*ROWS
// cells (2000 by default), one store write per cycle; no request is processed during it
// reset: synchronous, active low; cursor home, line count minus one, protection off,
// clear_on_full 1, then the same sweep fills the store with spaces in attribute 0x07
`timescale 1ns / 1ps

module text_console_char_writer_unit
    import tccw_pkg::*;
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_req i_in_req,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_res o_out_res,
    input  logic i_cfg_we,
    input  logic i_cfg_wdata
);

    localparam int CELLS  = COLUMNS * ROWS;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int COL_W  = $clog2(COLUMNS);
    localparam int ROW_W  = $clog2(ROWS);
    localparam int LC_W   = $clog2(ROWS) + 1;
    localparam int EXT_W  = (ADDR_W > POS_W) ? ADDR_W : POS_W;

    logic [15:0] mem [CELLS];

    t_state r_state, n_state;
    logic [ADDR_W-1:0] r_sweep_addr;

    logic r_req_valid;
    t_req r_req;
    logic r_out_valid;
    t_res r_out_res;

    logic [ROW_W-1:0] r_row, n_row;
    logic [COL_W-1:0] r_col, n_col;
    logic signed [LC_W-1:0] r_lc, n_lc;
    logic r_prot_on, n_prot_on;
    logic [COL_W-1:0] r_prot_col, n_prot_col;
    logic r_clear_on_full;

    logic w_fire;
    logic w_mem_we;
    logic [ADDR_W-1:0] w_mem_addr;
    logic [15:0] w_mem_data;

    logic w_wr;
    logic w_cleared;
    logic [COL_W-1:0] w_wcol;
    logic [7:0] w_wch;
    logic [7:0] w_wat;
    logic [ROW_W:0] w_row_ext;
    logic [COL_W:0] w_col_ext;
    logic [COL_W-1:0] w_limit;
    logic [ADDR_W-1:0] w_widx;
    logic [ADDR_W-1:0] w_cpos;
    logic [EXT_W-1:0] w_widx_ext;
    logic [EXT_W-1:0] w_cpos_ext;
    t_res w_res;

    assign o_in_ready  = !r_req_valid;
    assign o_out_valid = r_out_valid;
    assign o_out_res   = r_out_res;

    // request datapath
    always_comb begin
        n_row      = r_row;
        n_col      = r_col;
        n_lc       = r_lc;
        n_prot_on  = r_prot_on;
        n_prot_col = r_prot_col;
        w_wr       = 1'b0;
        w_cleared  = 1'b0;
        w_wcol     = r_col;
        w_wch      = 8'd0;
        w_wat      = 8'd0;
        w_row_ext  = {1'b0, r_row};
        w_col_ext  = {1'b0, r_col};
        w_limit    = r_prot_on ? r_prot_col : '0;
        case (r_req.cmd)
            CMD_PROT_ON: begin
                n_prot_on  = 1'b1;
                n_prot_col = r_col;
            end
            CMD_PROT_OFF: begin
                n_prot_on = 1'b0;
            end
            CMD_CLEAR: begin
                n_row     = '0;
                n_col     = '0;
                n_lc      = '0;
                w_cleared = 1'b1;
            end
            CMD_WRITE: begin
                if (r_req.char_code == CH_NEWLINE) begin
                    w_col_ext = '0;
                    w_row_ext = w_row_ext + 1'b1;
                    n_lc      = r_lc + 1'b1;
                end else if (r_req.char_code == CH_BACKSPACE) begin
                    if (r_col > w_limit) begin
                        w_col_ext = w_col_ext - 1'b1;
                        w_wcol    = r_col - 1'b1;
                        w_wr      = 1'b1;
                        w_wch     = CH_SPACE;
                        w_wat     = r_req.attribute;
                    end else if (!r_prot_on && r_row != '0) begin
                        w_row_ext = w_row_ext - 1'b1;
                        w_col_ext = (COL_W+1)'(COLUMNS - 1);
                    end
                end else begin
                    w_wr      = 1'b1;
                    w_wch     = r_req.char_code;
                    w_wat     = r_req.attribute;
                    w_col_ext = w_col_ext + 1'b1;
                end
                if (w_col_ext >= (COL_W+1)'(COLUMNS)) begin
                    w_col_ext = '0;
                    w_row_ext = w_row_ext + 1'b1;
                end
                if (w_row_ext >= (ROW_W+1)'(ROWS)) begin
                    w_row_ext = '0;
                end
                n_row = w_row_ext[ROW_W-1:0];
                n_col = w_col_ext[COL_W-1:0];
                if (n_lc >= $signed(LC_W'(ROWS - 1))) begin
                    n_lc = '0;
                    if (r_clear_on_full) begin
                        n_row     = '0;
                        n_col     = '0;
                        w_cleared = 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    assign w_widx     = ADDR_W'(r_row) * ADDR_W'(COLUMNS) + ADDR_W'(w_wcol);
    assign w_cpos     = ADDR_W'(n_row) * ADDR_W'(COLUMNS) + ADDR_W'(n_col);
    assign w_widx_ext = EXT_W'(w_widx);
    assign w_cpos_ext = EXT_W'(w_cpos);

    always_comb begin
        w_res.cell_written    = w_wr;
        w_res.cell_index      = w_wr ? w_widx_ext[POS_W-1:0] : '0;
        w_res.cell_char       = w_wch;
        w_res.cell_attr       = w_wat;
        w_res.cursor_position = w_cpos_ext[POS_W-1:0];
        w_res.screen_cleared  = w_cleared;
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_SWEEP: begin
                if (r_sweep_addr == ADDR_W'(CELLS - 1)) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                if (w_fire && w_cleared) begin
                    n_state = ST_SWEEP;
                end
            end
            default: n_state = ST_SWEEP;
        endcase
    end

    // outputs of the control
    always_comb begin
        w_fire     = 1'b0;
        w_mem_we   = 1'b0;
        w_mem_addr = w_widx;
        w_mem_data = {w_wat, w_wch};
        case (r_state)
            ST_SWEEP: begin
                w_mem_we   = 1'b1;
                w_mem_addr = r_sweep_addr;
                w_mem_data = {ATTR_BLANK, CH_SPACE};
            end
            ST_RUN: begin
                w_fire   = r_req_valid && (!r_out_valid || i_out_ready);
                w_mem_we = w_fire && w_wr;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            mem[w_mem_addr] <= w_mem_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= ST_SWEEP;
            r_sweep_addr    <= '0;
            r_req_valid     <= 1'b0;
            r_out_valid     <= 1'b0;
            r_row           <= '0;
            r_col           <= '0;
            r_lc            <= '1;
            r_prot_on       <= 1'b0;
            r_prot_col      <= '0;
            r_clear_on_full <= 1'b1;
        end else begin
            r_state <= n_state;
            if (r_state == ST_SWEEP) begin
                r_sweep_addr <= r_sweep_addr + 1'b1;
            end else begin
                r_sweep_addr <= '0;
            end
            if (i_cfg_we) begin
                r_clear_on_full <= i_cfg_wdata;
            end
            if (i_in_valid && o_in_ready) begin
                r_req_valid <= 1'b1;
            end else if (w_fire) begin
                r_req_valid <= 1'b0;
            end
            if (w_fire) begin
                r_out_valid <= 1'b1;
                r_row       <= n_row;
                r_col       <= n_col;
                r_lc        <= n_lc;
                r_prot_on   <= n_prot_on;
                r_prot_col  <= n_prot_col;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_req <= i_in_req;
        end
        if (w_fire) begin
            r_out_res <= w_res;
        end
    end

    a_no_fire_in_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_SWEEP |-> !w_fire)
        else $error("request processed during store sweep");

    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_row < ROW_W'(ROWS - 1) || r_row == ROW_W'(ROWS - 1))
        && (r_col < COL_W'(COLUMNS - 1) || r_col == COL_W'(COLUMNS - 1)))
        else $error("cursor out of range");

    a_clear_starts_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire && w_res.screen_cleared |=> r_state == ST_SWEEP)
        else $error("clear did not start sweep");

    a_line_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_lc < $signed(LC_W'(ROWS - 1)))
        else $error("line count out of range");

endmodule
